/* hw/rtl/dp_grid_min_plus_relaxation_macros.svh */
// Assertion macros shared by the min-plus relaxation RTL.
// Included by the modules that carry concurrent assertions; no other dependency.
`ifndef DP_GRID_MIN_PLUS_RELAXATION_MACROS_SVH
`define DP_GRID_MIN_PLUS_RELAXATION_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DPMP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DPMP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/dpmp_pkg.sv */
// Shared types and constants of the min-plus relaxation block.
// Used by the front end, the work queue, the back end and the top level.
package dpmp_pkg;

  // Default grid bounds.
  localparam int DEF_MAX_SPEED_POINTS = 8;
  localparam int DEF_MAX_TEMP_POINTS  = 8;

  // Fixed field widths.
  localparam int IDX_W     = 3;
  localparam int COST_W    = 32;
  localparam int CTRL_W    = 16;
  localparam int PTS_W     = 4;
  localparam int INF_W     = 31;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int PRED_W    = 2 * IDX_W;

  // Work queue depth between front and back end.
  localparam int QUEUE_DEPTH = 4;

  // Reset values of the configuration registers.
  localparam logic [PTS_W-1:0] PTS_RESET = 4'd8;
  localparam logic [INF_W-1:0] INF_RESET = '1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_POINTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_POINTS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INF_COST     = 2'd2;

  // Input mode codes.
  localparam logic [MODE_W-1:0] MODE_ARC    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_END    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_START  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_FINISH = 2'd3;

  // Operation carried from front to back end.
  typedef enum logic [1:0] {
    OP_ARC,
    OP_END,
    OP_START,
    OP_FINISH
  } op_t;

  // One queued unit of work.
  typedef struct packed {
    op_t                       op;
    logic [IDX_W-1:0]          fs;
    logic [IDX_W-1:0]          ft;
    logic [IDX_W-1:0]          ts;
    logic [IDX_W-1:0]          tt;
    logic signed [COST_W-1:0]  arc_cost;
    logic signed [CTRL_W-1:0]  ctl_force;
    logic signed [CTRL_W-1:0]  ctl_inlet;
    logic                      seed_ok;
  } work_t;

endpackage

/* hw/rtl/dpmp_front.sv */
// Front end: configuration registers and classification of input items.
// Depends on dpmp_pkg; pushes classified work into the work queue.
module dpmp_front
  import dpmp_pkg::*;
#(
  parameter int MAX_SPEED_POINTS = DEF_MAX_SPEED_POINTS,
  parameter int MAX_TEMP_POINTS  = DEF_MAX_TEMP_POINTS,
  localparam int SCW = $clog2(MAX_SPEED_POINTS + 1),
  localparam int TCW = $clog2(MAX_TEMP_POINTS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // Configuration write channel.
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [INF_W-1:0]         cfg_data,
  // Input item channel.
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic [IDX_W-1:0]         from_speed_idx,
  input  logic [IDX_W-1:0]         from_temp_idx,
  input  logic [IDX_W-1:0]         to_speed_idx,
  input  logic [IDX_W-1:0]         to_temp_idx,
  input  logic signed [COST_W-1:0] arc_cost,
  input  logic signed [CTRL_W-1:0] arc_force,
  input  logic signed [CTRL_W-1:0] arc_inlet,
  // Queue side.
  input  logic                     q_full,
  output logic                     push,
  output work_t                    push_entry,
  // Grid size in use and infinity for the back end.
  output logic [SCW-1:0]           used_s,
  output logic [TCW-1:0]           used_t,
  output logic [INF_W-1:0]         inf_cost
);

  logic [PTS_W-1:0] speed_cfg;
  logic [PTS_W-1:0] temp_cfg;
  logic [INF_W-1:0] inf_reg;
  logic             from_in;
  logic             to_in;
  logic             arc_feasible;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_cfg <= PTS_RESET;
      temp_cfg  <= PTS_RESET;
      inf_reg   <= INF_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_SPEED_POINTS: speed_cfg <= cfg_data[PTS_W-1:0];
        CFG_TEMP_POINTS:  temp_cfg  <= cfg_data[PTS_W-1:0];
        CFG_INF_COST:     inf_reg   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid size saturated to the range the store holds.
  always_comb begin
    if (speed_cfg == '0) begin
      used_s = SCW'(1);
    end else if (32'(speed_cfg) > 32'(MAX_SPEED_POINTS)) begin
      used_s = SCW'(MAX_SPEED_POINTS);
    end else begin
      used_s = SCW'(speed_cfg);
    end
    if (temp_cfg == '0) begin
      used_t = TCW'(1);
    end else if (32'(temp_cfg) > 32'(MAX_TEMP_POINTS)) begin
      used_t = TCW'(MAX_TEMP_POINTS);
    end else begin
      used_t = TCW'(temp_cfg);
    end
  end

  assign inf_cost = inf_reg;

  // Range and feasibility checks.
  assign from_in = (32'(from_speed_idx) < 32'(used_s)) && (32'(from_temp_idx) < 32'(used_t));
  assign to_in   = (32'(to_speed_idx) < 32'(used_s)) && (32'(to_temp_idx) < 32'(used_t));
  assign arc_feasible = $signed(arc_cost) < $signed({1'b0, inf_reg});

  assign item_stall = q_full;

  // Classify the accepted item; arcs that cannot count are dropped here.
  always_comb begin
    push_entry.op        = OP_ARC;
    push_entry.fs        = from_speed_idx;
    push_entry.ft        = from_temp_idx;
    push_entry.ts        = to_speed_idx;
    push_entry.tt        = to_temp_idx;
    push_entry.arc_cost  = arc_cost;
    push_entry.ctl_force = arc_force;
    push_entry.ctl_inlet = arc_inlet;
    push_entry.seed_ok   = from_in;
    push = 1'b0;
    if (item_valid && !item_stall) begin
      unique case (mode)
        MODE_ARC: begin
          push = from_in && to_in && arc_feasible;
        end
        MODE_END: begin
          push_entry.op = OP_END;
          push = 1'b1;
        end
        MODE_START: begin
          push_entry.op = OP_START;
          push = 1'b1;
        end
        default: begin
          push_entry.op = OP_FINISH;
          push = 1'b1;
        end
      endcase
    end
  end

endmodule

/* hw/rtl/dpmp_queue.sv */
// Short work queue that decouples the front end from the back end.
// Depends on dpmp_pkg for the work entry type and depth.
module dpmp_queue
  import dpmp_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t push_entry,
  input  logic  pop,
  output work_t head,
  output logic  full,
  output logic  empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  work_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/dpmp_back.sv */
// Back end: cost banks, relaxation datapath and the result sequencer.
// Depends on dpmp_pkg and the assertion macros header.
`include "dp_grid_min_plus_relaxation_macros.svh"

module dpmp_back
  import dpmp_pkg::*;
#(
  parameter int MAX_SPEED_POINTS = DEF_MAX_SPEED_POINTS,
  parameter int MAX_TEMP_POINTS  = DEF_MAX_TEMP_POINTS,
  localparam int SCW = $clog2(MAX_SPEED_POINTS + 1),
  localparam int TCW = $clog2(MAX_TEMP_POINTS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  // Queue side.
  input  logic                     q_empty,
  input  work_t                    q_head,
  output logic                     pop,
  // Grid size and infinity.
  input  logic [SCW-1:0]           used_s,
  input  logic [TCW-1:0]           used_t,
  input  logic [INF_W-1:0]         inf_cost,
  // Result channel.
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [IDX_W-1:0]         cell_speed_idx,
  output logic [IDX_W-1:0]         cell_temp_idx,
  output logic signed [COST_W-1:0] cell_cost,
  output logic [IDX_W-1:0]         pred_speed_idx,
  output logic [IDX_W-1:0]         pred_temp_idx,
  output logic signed [CTRL_W-1:0] best_force,
  output logic signed [CTRL_W-1:0] best_inlet,
  output logic                     reachable,
  output logic                     last_result
);

  localparam int CELLS = MAX_SPEED_POINTS * MAX_TEMP_POINTS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ARC_RD,
    S_ARC_SUM,
    S_ARC_WR,
    S_END_RD,
    S_END_EMIT,
    S_FIN_RD,
    S_FIN_CMP,
    S_FIN_EMIT
  } state_t;

  state_t state;

  // Two cost banks swap roles of previous and current at each end of stage.
  logic [COST_W-1:0] cost_mem0 [CELLS];
  logic [COST_W-1:0] cost_mem1 [CELLS];
  logic [PRED_W-1:0] pred_mem  [CELLS];
  logic [CTRL_W-1:0] force_mem [CELLS];
  logic [CTRL_W-1:0] inlet_mem [CELLS];

  logic [CELLS-1:0]  vld0;
  logic [CELLS-1:0]  vld1;
  logic [CELLS-1:0]  vld_aux;
  logic [INF_W-1:0]  clr0;
  logic [INF_W-1:0]  clr1;
  logic              cur_bank;

  work_t             op;
  logic [SCW-1:0]    s_cnt;
  logic [TCW-1:0]    t_cnt;
  logic [COST_W-1:0] sum_q;
  logic              arc_ok;
  logic [COST_W-1:0] cur_eff_q;
  logic [COST_W-1:0] best_cost;
  logic [IDX_W-1:0]  best_s;
  logic [IDX_W-1:0]  best_t;

  logic [AW-1:0]     from_addr;
  logic [AW-1:0]     to_addr;
  logic [AW-1:0]     scan_addr;
  logic [AW-1:0]     ra_cur;
  logic [AW-1:0]     ra_prev;
  logic [AW-1:0]     ra0;
  logic [AW-1:0]     ra1;
  logic [AW-1:0]     wa;
  logic [COST_W-1:0] wd;
  logic              we_cur;
  logic              we_seed;
  logic              we0;
  logic              we1;

  logic [COST_W-1:0] cq0;
  logic [COST_W-1:0] cq1;
  logic              vq0;
  logic              vq1;
  logic [PRED_W-1:0] pred_q;
  logic [CTRL_W-1:0] force_q;
  logic [CTRL_W-1:0] inlet_q;
  logic              avq;
  logic [COST_W-1:0] eff0;
  logic [COST_W-1:0] eff1;
  logic [COST_W-1:0] cur_data;
  logic [COST_W-1:0] prev_data;
  logic [COST_W-1:0] inf_wide;

  logic signed [COST_W:0] sum_wide;
  logic [COST_W-1:0]      sum_sat;
  logic                   prev_ok;
  logic                   t_last;
  logic                   scan_last;
  logic                   out_free;

  function automatic logic [AW-1:0] cell_addr(input logic [SCW-1:0] s, input logic [TCW-1:0] t);
    return AW'(32'(s) * MAX_TEMP_POINTS + 32'(t));
  endfunction

  // Address generation.
  assign from_addr = cell_addr(SCW'(op.fs), TCW'(op.ft));
  assign to_addr   = cell_addr(SCW'(op.ts), TCW'(op.tt));
  assign scan_addr = cell_addr(s_cnt, t_cnt);
  assign ra_cur    = (state == S_ARC_RD) ? to_addr : scan_addr;
  assign ra_prev   = (state == S_ARC_RD) ? from_addr : scan_addr;
  assign ra0       = cur_bank ? ra_prev : ra_cur;
  assign ra1       = cur_bank ? ra_cur : ra_prev;

  // Write control: relaxation writes the current bank, a start seeds the previous one.
  assign we_cur  = (state == S_ARC_WR) && arc_ok && ($signed(sum_q) < $signed(cur_eff_q));
  assign we_seed = (state == S_START) && op.seed_ok;
  assign we0     = cur_bank ? we_seed : we_cur;
  assign we1     = cur_bank ? we_cur : we_seed;
  assign wa      = (state == S_START) ? from_addr : to_addr;
  assign wd      = (state == S_START) ? '0 : sum_q;

  // Cost bank 0.
  always_ff @(posedge clk) begin
    if (we0) begin
      cost_mem0[wa] <= wd;
    end
    cq0 <= cost_mem0[ra0];
    vq0 <= vld0[ra0];
  end

  // Cost bank 1.
  always_ff @(posedge clk) begin
    if (we1) begin
      cost_mem1[wa] <= wd;
    end
    cq1 <= cost_mem1[ra1];
    vq1 <= vld1[ra1];
  end

  // Predecessor and control stores.
  always_ff @(posedge clk) begin
    if (we_cur) begin
      pred_mem[to_addr]  <= {op.fs, op.ft};
      force_mem[to_addr] <= op.ctl_force;
      inlet_mem[to_addr] <= op.ctl_inlet;
    end
    pred_q  <= pred_mem[scan_addr];
    force_q <= force_mem[scan_addr];
    inlet_q <= inlet_mem[scan_addr];
    avq     <= vld_aux[scan_addr];
  end

  // Entries never written since the last clear read as the clear value.
  assign inf_wide  = {1'b0, inf_cost};
  assign eff0      = vq0 ? cq0 : {1'b0, clr0};
  assign eff1      = vq1 ? cq1 : {1'b0, clr1};
  assign cur_data  = cur_bank ? eff1 : eff0;
  assign prev_data = cur_bank ? eff0 : eff1;

  // Saturating sum of previous cost and arc cost.
  assign sum_wide = $signed({prev_data[COST_W-1], prev_data})
                  + $signed({op.arc_cost[COST_W-1], op.arc_cost});
  assign prev_ok  = $signed(prev_data) < $signed(inf_wide);

  always_comb begin
    if (sum_wide > $signed({1'b0, inf_wide})) begin
      sum_sat = inf_wide;
    end else if (sum_wide[COST_W] && !sum_wide[COST_W-1]) begin
      sum_sat = {1'b1, {(COST_W-1){1'b0}}};
    end else begin
      sum_sat = sum_wide[COST_W-1:0];
    end
  end

  // Scan position.
  assign t_last    = (t_cnt == used_t - 1'b1);
  assign scan_last = t_last && (s_cnt == used_s - 1'b1);
  assign out_free  = !result_valid || !result_stall;
  assign pop       = (state == S_IDLE) && !q_empty;

  // Sequencer with the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_bank     <= 1'b0;
      clr0         <= INF_RESET;
      clr1         <= INF_RESET;
      vld0         <= '0;
      vld1         <= '0;
      vld_aux      <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (we_cur) begin
        if (cur_bank) begin
          vld1[to_addr] <= 1'b1;
        end else begin
          vld0[to_addr] <= 1'b1;
        end
        vld_aux[to_addr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (!q_empty) begin
            op    <= q_head;
            s_cnt <= '0;
            t_cnt <= '0;
            unique case (q_head.op)
              OP_ARC:   state <= S_ARC_RD;
              OP_END:   state <= S_END_RD;
              OP_START: state <= S_START;
              default: begin
                best_cost <= inf_wide;
                best_s    <= '0;
                best_t    <= '0;
                state     <= S_FIN_RD;
              end
            endcase
          end
        end
        S_START: begin
          // Clear everything, then mark the seeded initial cell.
          clr0    <= inf_cost;
          clr1    <= inf_cost;
          vld0    <= '0;
          vld1    <= '0;
          vld_aux <= '0;
          if (op.seed_ok) begin
            if (cur_bank) begin
              vld0[from_addr] <= 1'b1;
            end else begin
              vld1[from_addr] <= 1'b1;
            end
          end
          state <= S_IDLE;
        end
        S_ARC_RD: begin
          state <= S_ARC_SUM;
        end
        S_ARC_SUM: begin
          sum_q     <= sum_sat;
          arc_ok    <= prev_ok;
          cur_eff_q <= cur_data;
          state     <= S_ARC_WR;
        end
        S_ARC_WR: begin
          state <= S_IDLE;
        end
        S_END_RD: begin
          state <= S_END_EMIT;
        end
        S_END_EMIT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            cell_speed_idx <= IDX_W'(s_cnt);
            cell_temp_idx  <= IDX_W'(t_cnt);
            cell_cost      <= cur_data;
            pred_speed_idx <= avq ? pred_q[PRED_W-1:IDX_W] : '0;
            pred_temp_idx  <= avq ? pred_q[IDX_W-1:0] : '0;
            best_force     <= avq ? force_q : '0;
            best_inlet     <= avq ? inlet_q : '0;
            reachable      <= $signed(cur_data) < $signed(inf_wide);
            last_result    <= scan_last;
            if (scan_last) begin
              // Current becomes previous; the old previous bank is cleared.
              cur_bank <= !cur_bank;
              if (cur_bank) begin
                clr0 <= inf_cost;
                vld0 <= '0;
              end else begin
                clr1 <= inf_cost;
                vld1 <= '0;
              end
              vld_aux <= '0;
              state   <= S_IDLE;
            end else begin
              if (t_last) begin
                t_cnt <= '0;
                s_cnt <= s_cnt + 1'b1;
              end else begin
                t_cnt <= t_cnt + 1'b1;
              end
              state <= S_END_RD;
            end
          end
        end
        S_FIN_RD: begin
          state <= S_FIN_CMP;
        end
        S_FIN_CMP: begin
          if ($signed(prev_data) < $signed(best_cost)) begin
            best_cost <= prev_data;
            best_s    <= IDX_W'(s_cnt);
            best_t    <= IDX_W'(t_cnt);
          end
          if (scan_last) begin
            state <= S_FIN_EMIT;
          end else begin
            if (t_last) begin
              t_cnt <= '0;
              s_cnt <= s_cnt + 1'b1;
            end else begin
              t_cnt <= t_cnt + 1'b1;
            end
            state <= S_FIN_RD;
          end
        end
        S_FIN_EMIT: begin
          if (out_free) begin
            result_valid   <= 1'b1;
            cell_speed_idx <= best_s;
            cell_temp_idx  <= best_t;
            cell_cost      <= best_cost;
            pred_speed_idx <= '0;
            pred_temp_idx  <= '0;
            best_force     <= '0;
            best_inlet     <= '0;
            reachable      <= $signed(best_cost) < $signed(inf_wide);
            last_result    <= 1'b1;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Work is taken from the queue only between operations.
  `DPMP_ASSERT_IMP(a_pop_in_idle, clk, rst, pop, state == S_IDLE, "queue popped while busy")
  // A relaxation write hands control straight back to idle.
  `DPMP_ASSERT_NXT(a_arc_done, clk, rst, state == S_ARC_WR, state == S_IDLE, "arc write not done")
  // A current-bank write only happens with a feasible origin.
  `DPMP_ASSERT_IMP(a_write_ok, clk, rst, we_cur, arc_ok && state == S_ARC_WR, "bad relax write")

endmodule

/* hw/rtl/dp_grid_min_plus_relaxation.sv */
// Top level of the min-plus relaxation engine for forward dynamic programming.
// Depends on dpmp_pkg, dpmp_front, dpmp_queue and dpmp_back.
//
// Usage:
//   Input items arrive on item_valid / item_stall with the mode and arc fields;
//   a transaction is taken when item_valid is high and item_stall is low.
//   Results leave on result_valid / result_stall, one cell per transaction.
//   Registers (grid sizes, infinity) are written on cfg_valid / cfg_ready,
//   always high; users must write only while the engine is idle (not enforced).
// Operation:
//   Items are classified on entry and queued (four deep); the back end runs
//   one item at a time. An arc passes through pop, read of both cost banks,
//   saturating add, then compare and write. Start clears the banks and seeds
//   the initial cell when it lies in the grid. End of stage does one bank read
//   and one output load per cell. Finish scans the previous bank, one read and
//   one compare per cell, then emits one result. Arcs dropped as out of grid
//   or infeasible cost no back-end time.
// Reset and stalls:
//   Reset restores the registers to an 8 x 8 grid with the largest infinity
//   and marks every cell as cleared at once; no clearing pass is needed.
//   A stalled result holds the output register and pauses the cell scan.
module dp_grid_min_plus_relaxation
  import dpmp_pkg::*;
#(
  parameter int MAX_SPEED_POINTS = DEF_MAX_SPEED_POINTS,
  parameter int MAX_TEMP_POINTS  = DEF_MAX_TEMP_POINTS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [INF_W-1:0]         cfg_data,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [MODE_W-1:0]        mode,
  input  logic [IDX_W-1:0]         from_speed_idx,
  input  logic [IDX_W-1:0]         from_temp_idx,
  input  logic [IDX_W-1:0]         to_speed_idx,
  input  logic [IDX_W-1:0]         to_temp_idx,
  input  logic signed [COST_W-1:0] arc_cost,
  input  logic signed [CTRL_W-1:0] arc_force,
  input  logic signed [CTRL_W-1:0] arc_inlet,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic [IDX_W-1:0]         cell_speed_idx,
  output logic [IDX_W-1:0]         cell_temp_idx,
  output logic signed [COST_W-1:0] cell_cost,
  output logic [IDX_W-1:0]         pred_speed_idx,
  output logic [IDX_W-1:0]         pred_temp_idx,
  output logic signed [CTRL_W-1:0] best_force,
  output logic signed [CTRL_W-1:0] best_inlet,
  output logic                     reachable,
  output logic                     last_result
);

  localparam int SCW = $clog2(MAX_SPEED_POINTS + 1);
  localparam int TCW = $clog2(MAX_TEMP_POINTS + 1);

  logic             push;
  work_t            push_entry;
  logic             pop;
  work_t            q_head;
  logic             q_full;
  logic             q_empty;
  logic [SCW-1:0]   used_s;
  logic [TCW-1:0]   used_t;
  logic [INF_W-1:0] inf_cost;

  // Classification and configuration.
  dpmp_front #(
    .MAX_SPEED_POINTS(MAX_SPEED_POINTS),
    .MAX_TEMP_POINTS (MAX_TEMP_POINTS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .mode           (mode),
    .from_speed_idx (from_speed_idx),
    .from_temp_idx  (from_temp_idx),
    .to_speed_idx   (to_speed_idx),
    .to_temp_idx    (to_temp_idx),
    .arc_cost       (arc_cost),
    .arc_force      (arc_force),
    .arc_inlet      (arc_inlet),
    .q_full         (q_full),
    .push           (push),
    .push_entry     (push_entry),
    .used_s         (used_s),
    .used_t         (used_t),
    .inf_cost       (inf_cost)
  );

  // Work queue.
  dpmp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Relaxation and result sequencing.
  dpmp_back #(
    .MAX_SPEED_POINTS(MAX_SPEED_POINTS),
    .MAX_TEMP_POINTS (MAX_TEMP_POINTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .pop            (pop),
    .used_s         (used_s),
    .used_t         (used_t),
    .inf_cost       (inf_cost),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .cell_speed_idx (cell_speed_idx),
    .cell_temp_idx  (cell_temp_idx),
    .cell_cost      (cell_cost),
    .pred_speed_idx (pred_speed_idx),
    .pred_temp_idx  (pred_temp_idx),
    .best_force     (best_force),
    .best_inlet     (best_inlet),
    .reachable      (reachable),
    .last_result    (last_result)
  );

endmodule
